// ===== sv/lfsc_pkg.sv =====
package lfsc_pkg;

  localparam int GrayW  = 8;
  localparam int ClipW  = 8;
  localparam int LevelW = 10;
  localparam int CountW = 8;
  localparam int SpeedW = 11;
  localparam int IndexW = 3;
  localparam int DataW  = 10;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [IndexW-1:0] {
    REG_LINE_THRESHOLD     = 3'd0,
    REG_STEP_CLIP          = 3'd1,
    REG_CRUISE_SPEED       = 3'd2,
    REG_GENTLE_SPEED       = 3'd3,
    REG_BOOST_SPEED        = 3'd4,
    REG_BOOST_AFTER        = 3'd5,
    REG_TURN_SLOW_TICKS    = 3'd6,
    REG_TURN_REVERSE_TICKS = 3'd7
  } lfsc_reg_t;

  typedef struct packed {
    logic [GrayW-1:0]  line_threshold;
    logic [ClipW-1:0]  step_clip;
    logic [LevelW-1:0] cruise_speed;
    logic [LevelW-1:0] gentle_speed;
    logic [LevelW-1:0] boost_speed;
    logic [CountW-1:0] boost_after;
    logic [CountW-1:0] turn_slow_ticks;
    logic [CountW-1:0] turn_reverse_ticks;
  } lfsc_cfg_t;

  localparam lfsc_cfg_t CfgReset = '{
    line_threshold:     8'd127,
    step_clip:          8'd10,
    cruise_speed:       10'd30,
    gentle_speed:       10'd20,
    boost_speed:        10'd660,
    boost_after:        8'd10,
    turn_slow_ticks:    8'd5,
    turn_reverse_ticks: 8'd10
  };

  // Saturating count up.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = (c == CountMax) ? c : c + 1'b1;
    return r;
  endfunction

  // Move now toward target by at most clip.
  function automatic logic signed [SpeedW-1:0] slew(
    input logic signed [SpeedW-1:0] now,
    input logic signed [SpeedW-1:0] target,
    input logic [ClipW-1:0]         clip
  );
    logic signed [SpeedW:0] diff;
    logic signed [SpeedW:0] lim;
    logic signed [SpeedW:0] sum;
    diff = {target[SpeedW-1], target} - {now[SpeedW-1], now};
    lim  = $signed({{(SpeedW + 1 - ClipW){1'b0}}, clip});
    if (diff > lim) begin
      diff = lim;
    end else if (diff < -lim) begin
      diff = -lim;
    end
    sum = {now[SpeedW-1], now} + diff;
    return sum[SpeedW-1:0];
  endfunction

endpackage

// ===== sv/line_follower_speed_control_unit.sv =====
// Line-follower wheel speed control. Each item carries three gray samples
// (left, center, right); a sample below line_threshold means that sensor sees
// the line. The block keeps the last non-empty sighting, chooses wheel targets
// (gentle corrections, straight with boost after a long run, staged hard turns)
// and slews each wheel speed toward its target by at most step_clip, returning
// one item with both new speeds per input item. An item is registered on
// entry in the input register and its result lands in the result register
// once the result slot is free or being emptied; the result register is also
// the speed state. One item is accepted every cycle as long as results are
// taken, and the input register holds one more item while a result waits.
// Configuration registers (index 0..7) are written through cfg_valid/cfg_ready
// and take effect for items that advance after the write; write them while idle.
module line_follower_speed_control_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lfsc_pkg::GrayW-1:0]          left_gray,
  input  logic [lfsc_pkg::GrayW-1:0]          center_gray,
  input  logic [lfsc_pkg::GrayW-1:0]          right_gray,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lfsc_pkg::SpeedW-1:0]  left_wheel_speed,
  output logic signed [lfsc_pkg::SpeedW-1:0]  right_wheel_speed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lfsc_pkg::IndexW-1:0]         cfg_index,
  input  logic [lfsc_pkg::DataW-1:0]          cfg_data
);
  import lfsc_pkg::*;

  lfsc_cfg_t         cfg;
  logic              stage_valid;
  logic [GrayW-1:0]  stage_left, stage_center, stage_right;
  logic              advance;

  // Advance the staged item when the result slot is free or being emptied.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  lfsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: control bit cleared by reset, payload held.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_left   <= left_gray;
      stage_center <= center_gray;
      stage_right  <= right_gray;
    end
  end

  // Result valid: set by an advancing item, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The speed state doubles as the result register.
  lfsc_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .advance         (advance),
    .left_gray       (stage_left),
    .center_gray     (stage_center),
    .right_gray      (stage_right),
    .left_speed_now  (left_wheel_speed),
    .right_speed_now (right_wheel_speed)
  );

endmodule

// ===== sv/lfsc_cfg_regs.sv =====
module lfsc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfsc_pkg::IndexW-1:0] cfg_index,
  input  logic [lfsc_pkg::DataW-1:0]  cfg_data,
  output lfsc_pkg::lfsc_cfg_t        cfg
);
  import lfsc_pkg::*;

  lfsc_cfg_t cfg_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      unique case (lfsc_reg_t'(cfg_index))
        REG_LINE_THRESHOLD:     cfg_next.line_threshold     = cfg_data[GrayW-1:0];
        REG_STEP_CLIP:          cfg_next.step_clip          = cfg_data[ClipW-1:0];
        REG_CRUISE_SPEED:       cfg_next.cruise_speed       = cfg_data[LevelW-1:0];
        REG_GENTLE_SPEED:       cfg_next.gentle_speed       = cfg_data[LevelW-1:0];
        REG_BOOST_SPEED:        cfg_next.boost_speed        = cfg_data[LevelW-1:0];
        REG_BOOST_AFTER:        cfg_next.boost_after        = cfg_data[CountW-1:0];
        REG_TURN_SLOW_TICKS:    cfg_next.turn_slow_ticks    = cfg_data[CountW-1:0];
        REG_TURN_REVERSE_TICKS: cfg_next.turn_reverse_ticks = cfg_data[CountW-1:0];
        default:                cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== sv/lfsc_ctrl.sv =====
module lfsc_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  lfsc_pkg::lfsc_cfg_t                cfg,
  input  logic                               advance,
  input  logic [lfsc_pkg::GrayW-1:0]         left_gray,
  input  logic [lfsc_pkg::GrayW-1:0]         center_gray,
  input  logic [lfsc_pkg::GrayW-1:0]         right_gray,
  output logic signed [lfsc_pkg::SpeedW-1:0] left_speed_now,
  output logic signed [lfsc_pkg::SpeedW-1:0] right_speed_now
);
  import lfsc_pkg::*;

  logic                     held_left, held_center, held_right;
  logic                     held_left_next, held_center_next, held_right_next;
  logic [CountW-1:0]        turn_count, turn_count_next;
  logic [CountW-1:0]        straight_count, straight_count_next;
  logic signed [SpeedW-1:0] left_speed_now_next, right_speed_now_next;

  logic                     on_l, on_c, on_r;
  logic [CountW-1:0]        turn_inc, straight_inc;
  logic signed [SpeedW-1:0] half, cruise, gentle, boost, turn_target;
  logic signed [SpeedW-1:0] left_goal, right_goal;

  assign on_l = left_gray   < cfg.line_threshold;
  assign on_c = center_gray < cfg.line_threshold;
  assign on_r = right_gray  < cfg.line_threshold;

  assign half   = $signed({2'b00, cfg.cruise_speed[LevelW-1:1]});
  assign cruise = $signed({1'b0, cfg.cruise_speed});
  assign gentle = $signed({1'b0, cfg.gentle_speed});
  assign boost  = $signed({1'b0, cfg.boost_speed});

  assign turn_inc     = sat_inc(turn_count);
  assign straight_inc = sat_inc(straight_count);

  always_comb begin
    // Keep the last sighting when no sensor sees the line.
    if (on_l || on_c || on_r) begin
      held_left_next   = on_l;
      held_center_next = on_c;
      held_right_next  = on_r;
    end else begin
      held_left_next   = held_left;
      held_center_next = held_center;
      held_right_next  = held_right;
    end

    turn_count_next     = turn_count;
    straight_count_next = straight_count;
    turn_target         = '0;
    if (held_left_next || held_right_next) begin
      turn_count_next     = turn_inc;
      straight_count_next = '0;
      priority if (turn_inc < cfg.turn_slow_ticks) begin
        turn_target = half;
      end else if (turn_inc < cfg.turn_reverse_ticks) begin
        turn_target = '0;
      end else begin
        turn_target = -half;
      end
    end

    priority if (held_center_next && held_left_next) begin
      left_goal  = gentle;
      right_goal = cruise;
    end else if (held_center_next && held_right_next) begin
      left_goal  = cruise;
      right_goal = gentle;
    end else if (held_center_next) begin
      turn_count_next     = '0;
      straight_count_next = straight_inc;
      left_goal  = (straight_inc > cfg.boost_after) ? boost : cruise;
      right_goal = left_goal;
    end else if (held_left_next) begin
      left_goal  = turn_target;
      right_goal = half;
    end else if (held_right_next) begin
      left_goal  = half;
      right_goal = turn_target;
    end else begin
      left_goal  = left_speed_now;
      right_goal = right_speed_now;
    end

    left_speed_now_next  = slew(left_speed_now, left_goal, cfg.step_clip);
    right_speed_now_next = slew(right_speed_now, right_goal, cfg.step_clip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left       <= 1'b0;
      held_center     <= 1'b0;
      held_right      <= 1'b0;
      turn_count      <= '0;
      straight_count  <= '0;
      left_speed_now  <= '0;
      right_speed_now <= '0;
    end else if (advance) begin
      held_left       <= held_left_next;
      held_center     <= held_center_next;
      held_right      <= held_right_next;
      turn_count      <= turn_count_next;
      straight_count  <= straight_count_next;
      left_speed_now  <= left_speed_now_next;
      right_speed_now <= right_speed_now_next;
    end
  end

endmodule

// ===== sv/lfsc_checker.sv =====
module lfsc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [lfsc_pkg::SpeedW-1:0] left_wheel_speed,
  input logic signed [lfsc_pkg::SpeedW-1:0] right_wheel_speed
);
  import lfsc_pkg::*;

  // No result right after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("result valid right after reset");

  // Input stalls only behind a waiting, untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

  // A waiting result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_wheel_speed)
                                && $stable(right_wheel_speed))
    else $error("result changed while stalled");

  // Speeds stay at or above minus half the largest cruise.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_wheel_speed >= -11'sd511) && (right_wheel_speed >= -11'sd511))
    else $error("wheel speed out of range");

endmodule

bind line_follower_speed_control_unit lfsc_checker u_lfsc_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .left_wheel_speed  (left_wheel_speed),
  .right_wheel_speed (right_wheel_speed)
);
